### rtl/core/smsd_pkg.sv
// shared constants and controller/datapath interface types for the median spike detector
package smsd_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int BIN_W        = 8;
    localparam int HIST_DEPTH   = 256;
    localparam int BIN_MAX      = HIST_DEPTH - 1;
    localparam int DM_W         = 9;
    localparam int TOTAL_W      = 32;
    localparam int WLEN_W       = 11;
    localparam int WLEN_RESET   = 5;
    localparam int MAX_WINDOW   = 1024;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 48;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic old_rd;
        logic dec_wr;
        logic inc_rd;
        logic inc_wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

### rtl/core/smsd_ctrl.sv
// sequencing state machine for the median spike detector
module smsd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  smsd_pkg::t_dp_status  i_status,
    output smsd_pkg::t_dp_cmd     o_cmd
);
    import smsd_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SCAN      = 3'd1;
    localparam logic [2:0] ST_SCAN_TAIL = 3'd2;
    localparam logic [2:0] ST_DEC_WR    = 3'd3;
    localparam logic [2:0] ST_INC_RD    = 3'd4;
    localparam logic [2:0] ST_INC_WR    = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.full ? ST_SCAN : ST_INC_RD;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_SCAN_TAIL;
                end
            end
            ST_SCAN_TAIL: begin
                o_cmd.old_rd = 1'b1;
                n_state      = ST_DEC_WR;
            end
            ST_DEC_WR: begin
                o_cmd.dec_wr = 1'b1;
                n_state      = ST_INC_RD;
            end
            ST_INC_RD: begin
                o_cmd.inc_rd = 1'b1;
                n_state      = ST_INC_WR;
            end
            ST_INC_WR: begin
                o_cmd.inc_wr = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_SCAN || r_state == ST_INC_RD))
        else $error("item load did not start scan or update");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.old_rd |=> o_cmd.dec_wr ##1 o_cmd.inc_rd ##1 o_cmd.inc_wr)
        else $error("histogram update sequence broken");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(o_cmd) <= 1)
        else $error("more than one datapath command at once");

endmodule

### rtl/core/smsd_dp.sv
// datapath: histogram memory, sample ring, median scan and result register
module smsd_dp #(
    parameter int P_MAX_WINDOW = smsd_pkg::MAX_WINDOW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smsd_pkg::t_dp_cmd                 i_cmd,
    output smsd_pkg::t_dp_status              o_status,
    input  logic [smsd_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                              i_cfg_valid,
    input  logic [smsd_pkg::WLEN_W-1:0]       i_cfg_data,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [smsd_pkg::M_TDATA_W-1:0]    o_m_tdata
);
    import smsd_pkg::*;

    localparam int WIN_W     = $clog2(P_MAX_WINDOW + 1);
    localparam int PTR_W     = (P_MAX_WINDOW > 1) ? $clog2(P_MAX_WINDOW) : 1;
    localparam int WIN_RESET = (WLEN_RESET > P_MAX_WINDOW) ? P_MAX_WINDOW : WLEN_RESET;

    // histogram and sample ring
    logic [WIN_W-1:0]    r_hist_mem [HIST_DEPTH];
    logic [BIN_W-1:0]    r_ring_mem [P_MAX_WINDOW];
    logic [HIST_DEPTH-1:0] r_bin_valid;
    logic [WIN_W-1:0]    r_hist_q;
    logic                r_q_valid;
    logic [BIN_W-1:0]    r_rd_addr;
    logic [BIN_W-1:0]    r_old_q;
    logic                r_rd_scan;

    // window control
    logic [WIN_W-1:0]    r_win;
    logic [WIN_W-1:0]    r_held;
    logic [PTR_W-1:0]    r_pos;

    // per-item working registers
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_full;
    logic [BIN_W-1:0]    r_scan_addr;
    logic [WIN_W-1:0]    r_acc;
    logic                r_lo_found;
    logic                r_hi_found;
    logic [BIN_W-1:0]    r_lo;
    logic [BIN_W-1:0]    r_hi;

    logic [TOTAL_W-1:0]  r_alert_total;
    logic                r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    logic [WIN_W-1:0]    n_win;
    logic [BIN_W-1:0]    hist_ra;
    logic                hist_we;
    logic [WIN_W-1:0]    hist_wd;
    logic [WIN_W-1:0]    cnt_q;
    logic [WIN_W:0]      lo_rank_x;
    logic [WIN_W:0]      hi_rank_x;
    logic [WIN_W-1:0]    lo_rank;
    logic [WIN_W-1:0]    hi_rank;
    logic [WIN_W-1:0]    acc_sum;
    logic [PTR_W-1:0]    pos_eff;
    logic [WIN_W-1:0]    pos_inc;
    logic [PTR_W-1:0]    pos_next;
    logic [DM_W-1:0]     dm;
    logic                alert;
    logic [TOTAL_W-1:0]  n_alert_total;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_win = WIN_W'(1);
        end else if (32'(i_cfg_data) > 32'(P_MAX_WINDOW)) begin
            n_win = WIN_W'(P_MAX_WINDOW);
        end else begin
            n_win = WIN_W'(i_cfg_data);
        end
    end

    assign lo_rank_x = ({1'b0, r_win} + (WIN_W+1)'(1)) >> 1;
    assign hi_rank_x = ({1'b0, r_win} + (WIN_W+1)'(2)) >> 1;
    assign lo_rank   = lo_rank_x[WIN_W-1:0];
    assign hi_rank   = hi_rank_x[WIN_W-1:0];

    assign hist_ra = i_cmd.scan_rd ? r_scan_addr :
                     i_cmd.old_rd  ? r_old_q     : r_sample;
    assign cnt_q   = r_q_valid ? r_hist_q : '0;
    assign acc_sum = r_acc + cnt_q;
    assign hist_we = i_cmd.dec_wr | i_cmd.inc_wr;

    always_comb begin
        if (i_cmd.dec_wr) begin
            hist_wd = (cnt_q == '0) ? '0 : cnt_q - WIN_W'(1);
        end else begin
            hist_wd = cnt_q + WIN_W'(1);
        end
    end

    assign pos_eff  = (WIN_W'(r_pos) >= r_win) ? '0 : r_pos;
    assign pos_inc  = WIN_W'(r_pos) + WIN_W'(1);
    assign pos_next = (pos_inc >= r_win) ? '0 : pos_inc[PTR_W-1:0];

    assign dm    = r_full ? (DM_W'(r_lo) + DM_W'(r_hi)) : '0;
    assign alert = r_full && (DM_W'(r_sample) >= dm);
    assign n_alert_total = (alert && (r_alert_total != '1)) ?
                           r_alert_total + TOTAL_W'(1) : r_alert_total;

    // memories
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[r_rd_addr] <= hist_wd;
        end
        r_hist_q  <= r_hist_mem[hist_ra];
        r_q_valid <= r_bin_valid[hist_ra];
        r_rd_addr <= hist_ra;
        if (i_cmd.inc_wr) begin
            r_ring_mem[r_pos] <= r_sample;
        end
        r_old_q <= r_ring_mem[r_pos];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_full   <= (r_held >= r_win);
        end
        if (i_cmd.out_load) begin
            r_m_data <= {(M_TDATA_W-TOTAL_W-DM_W-2)'(0), n_alert_total, dm, r_full, alert};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_valid   <= '0;
            r_win         <= WIN_W'(WIN_RESET);
            r_held        <= '0;
            r_pos         <= '0;
            r_rd_scan     <= 1'b0;
            r_scan_addr   <= '0;
            r_acc         <= '0;
            r_lo_found    <= 1'b0;
            r_hi_found    <= 1'b0;
            r_lo          <= '0;
            r_hi          <= '0;
            r_alert_total <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            r_rd_scan <= i_cmd.scan_rd;
            if (i_cfg_valid) begin
                r_bin_valid <= '0;
                r_win       <= n_win;
                r_held      <= '0;
                r_pos       <= '0;
            end else begin
                if (hist_we) begin
                    r_bin_valid[r_rd_addr] <= 1'b1;
                end
                if (i_cmd.load) begin
                    r_pos <= pos_eff;
                end
                if (i_cmd.inc_wr) begin
                    r_pos <= pos_next;
                    if (!r_full) begin
                        r_held <= r_held + WIN_W'(1);
                    end
                end
            end
            if (i_cmd.load) begin
                r_scan_addr <= '0;
                r_acc       <= '0;
                r_lo_found  <= 1'b0;
                r_hi_found  <= 1'b0;
                r_lo        <= BIN_W'(BIN_MAX);
                r_hi        <= BIN_W'(BIN_MAX);
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan_addr <= r_scan_addr + BIN_W'(1);
                end
                if (r_rd_scan) begin
                    r_acc <= acc_sum;
                    if (!r_lo_found && acc_sum >= lo_rank) begin
                        r_lo       <= r_rd_addr;
                        r_lo_found <= 1'b1;
                    end
                    if (!r_hi_found && acc_sum >= hi_rank) begin
                        r_hi       <= r_rd_addr;
                        r_hi_found <= 1'b1;
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_alert_total <= n_alert_total;
                r_m_valid     <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_status.full      = (r_held >= r_win);
    assign o_status.scan_last = (r_scan_addr == BIN_W'(BIN_MAX));
    assign o_status.out_free  = !r_m_valid || i_m_tready;
    assign o_m_tvalid         = r_m_valid;
    assign o_m_tdata          = r_m_data;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WIN_W'(r_pos) < r_win)
        else $error("ring position outside window");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= r_win)
        else $error("held sample count exceeds window");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_scan |-> (r_acc <= r_held))
        else $error("histogram scan total exceeds held samples");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_alert_total != $past(r_alert_total)))
            |-> (r_alert_total == $past(r_alert_total) + TOTAL_W'(1)))
        else $error("alert total moved by other than one");

endmodule

### rtl/core/sliding_median_spike_detector_core.sv
// top level of the sliding-window median spike detector
// Each item carries one 8-bit sample. Once the window holds window_len samples, the sample is
// compared with the sum of the two middle values of the previous window, found by a scan
// over a 256-bin histogram that reads one bin per cycle from a single-port-read memory.
// Per item: accept; if the window is full, scan the histogram, then decrement the oldest sample's
// bin; increment the new sample's bin; load the result, waiting while the previous one is untaken.
// No new item is accepted until then. Writing window_len restarts the window (histogram bins
// cleared at once, alert total kept).
module sliding_median_spike_detector_core #(
    parameter int P_MAX_WINDOW = smsd_pkg::MAX_WINDOW
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sample[7:0]
    input  logic [smsd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // alert[0], window_full[1], median_sum[10:2], alert_count[42:11], zero fill
    output logic [smsd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [smsd_pkg::WLEN_W-1:0]        i_cfg_data
);
    import smsd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    smsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    smsd_dp #(
        .P_MAX_WINDOW (P_MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

### bench/sliding_median_spike_detector_core_test.sv
// self-checking testbench for the sliding-window median spike detector core
module sliding_median_spike_detector_core_test;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT       = 100_000_000;
    localparam int BIN_TOP       = smsd_pkg::HIST_DEPTH - 1;
    localparam int LEN_W         = smsd_pkg::WLEN_W;
    localparam int SAMPLE_BITS   = smsd_pkg::SAMPLE_W;

    typedef struct packed {
        logic [smsd_pkg::TOTAL_W-1:0] alert_count;
        logic [smsd_pkg::DM_W-1:0]    median_sum;
        logic                         window_full;
        logic                         alert;
    } t_verdict;

    localparam int VERDICT_W = $bits(t_verdict);

    typedef struct packed {
        logic [smsd_pkg::SAMPLE_W-1:0] sample;
        logic                          typed;
        t_verdict                      verdict;
    } t_directed_row;

    typedef struct packed {
        logic [smsd_pkg::WLEN_W-1:0] len;
        logic [11:0]                 items;
        logic                        rand_len;
        logic                        hold;
    } t_phase;

    localparam int DIRECTED_ROWS = 20;
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        '{8'd0,   1'b1, '0},
        '{8'd255, 1'b1, '0},
        '{8'd128, 1'b1, '0},
        '{8'd1,   1'b1, '0},
        '{8'd254, 1'b1, '0},
        '{8'd255, 1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd7,   1'b0, '0},
        '{8'd7,   1'b0, '0},
        '{8'd7,   1'b0, '0},
        '{8'd6,   1'b0, '0},
        '{8'd14,  1'b0, '0},
        '{8'd13,  1'b0, '0},
        '{8'd255, 1'b0, '0},
        '{8'd128, 1'b0, '0}
    };

    localparam int PHASES = 11;
    localparam t_phase PHASE_PLAN [PHASES] = '{
        '{11'd1,    12'd100,  1'b0, 1'b0},
        '{11'd0,    12'd80,   1'b0, 1'b0},
        '{11'd2,    12'd100,  1'b0, 1'b0},
        '{11'd3,    12'd90,   1'b0, 1'b0},
        '{11'd6,    12'd90,   1'b0, 1'b0},
        '{11'd64,   12'd110,  1'b0, 1'b0},
        '{11'd1024, 12'd60,   1'b0, 1'b1},
        '{11'd2047, 12'd40,   1'b0, 1'b0},
        '{11'd0,    12'd120,  1'b1, 1'b0},
        '{11'd4,    12'd80,   1'b0, 1'b0},
        '{11'd5,    12'd60,   1'b0, 1'b0}
    };

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [smsd_pkg::S_TDATA_W-1:0]    s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [smsd_pkg::M_TDATA_W-1:0]    m_axis_tdata;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [smsd_pkg::WLEN_W-1:0]       i_cfg_data;

    // predictor state
    int unsigned                   bin_count [smsd_pkg::HIST_DEPTH];
    logic [smsd_pkg::SAMPLE_W-1:0] past_samples [smsd_pkg::MAX_WINDOW];
    int unsigned                   ring_slot;
    int unsigned                   held_count;
    logic [smsd_pkg::TOTAL_W-1:0]  spike_total;
    logic [smsd_pkg::WLEN_W-1:0]   window_setting;

    t_verdict    pending_verdicts [$];
    int unsigned mismatches;
    bit          hold_pending;
    int unsigned sent_count;
    bit          send_burst;

    sliding_median_spike_detector_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void restart_window();
        for (int v = 0; v <= BIN_TOP; v++) begin
            bin_count[v] = 0;
        end
        ring_slot  = 0;
        held_count = 0;
    endfunction

    function automatic int unsigned window_span();
        if (window_setting == '0) begin
            return 1;
        end
        if (window_setting > smsd_pkg::MAX_WINDOW) begin
            return smsd_pkg::MAX_WINDOW;
        end
        return 32'(window_setting);
    endfunction

    function automatic t_verdict spike_verdict(input logic [smsd_pkg::SAMPLE_W-1:0] s);
        int unsigned w;
        int unsigned pos;
        int unsigned lo_rank;
        int unsigned hi_rank;
        int unsigned acc;
        int unsigned lo_v;
        int unsigned hi_v;
        int unsigned dm;
        bit          lo_hit;
        bit          hi_hit;
        logic [smsd_pkg::SAMPLE_W-1:0] oldest;
        t_verdict    r;
        r   = '0;
        w   = window_span();
        pos = ring_slot;
        if (pos >= w) begin
            pos = 0;
        end
        if (held_count >= w) begin
            r.window_full = 1'b1;
            lo_rank = (w + 1) / 2;
            hi_rank = (w + 2) / 2;
            lo_v    = BIN_TOP;
            hi_v    = BIN_TOP;
            lo_hit  = 1'b0;
            hi_hit  = 1'b0;
            acc     = 0;
            for (int v = 0; v <= BIN_TOP; v++) begin
                acc += bin_count[v];
                if (!lo_hit && acc >= lo_rank) begin
                    lo_v   = v;
                    lo_hit = 1'b1;
                end
                if (!hi_hit && acc >= hi_rank) begin
                    hi_v   = v;
                    hi_hit = 1'b1;
                end
            end
            dm = lo_v + hi_v;
            r.median_sum = dm[smsd_pkg::DM_W-1:0];
            if (s >= dm) begin
                r.alert = 1'b1;
                if (spike_total != '1) begin
                    spike_total = spike_total + 1'b1;
                end
            end
            oldest = past_samples[pos];
            if (bin_count[oldest] > 0) begin
                bin_count[oldest] = bin_count[oldest] - 1;
            end
        end else begin
            held_count++;
        end
        bin_count[s]      = bin_count[s] + 1;
        past_samples[pos] = s;
        pos++;
        if (pos >= w) begin
            pos = 0;
        end
        ring_slot     = pos;
        r.alert_count = spike_total;
        return r;
    endfunction

    function automatic logic [smsd_pkg::SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SAMPLE_BITS'($urandom_range(0, 31));
            4, 5:       return SAMPLE_BITS'($urandom_range(128, 255));
            6, 7:       return SAMPLE_BITS'($urandom_range(0, 255));
            8:          return '0;
            default:    return '1;
        endcase
    endfunction

    // returns with the item accepted at the current edge, tvalid still high
    task automatic send_sample(input logic [smsd_pkg::SAMPLE_W-1:0] s, output bit taken);
        int unsigned gap;
        if (sent_count % 64 == 0) begin
            send_burst = ($urandom_range(0, 3) == 0);
        end
        sent_count++;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        taken = 1'b1;
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_len(input logic [smsd_pkg::WLEN_W-1:0] len);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid    <= 1'b0;
        window_setting  = len;
        restart_window();
    endtask

    // result checker
    initial begin
        int unsigned stall;
        int unsigned taken_count;
        bit          take_burst;
        t_verdict    got;
        t_verdict    want;
        taken_count = 0;
        take_burst  = 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (taken_count % 64 == 0) begin
                take_burst = ($urandom_range(0, 3) == 0);
            end
            taken_count++;
            stall = take_burst ? 0 : $urandom_range(0, 15);
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            got = t_verdict'(m_axis_tdata[VERDICT_W-1:0]);
            if (pending_verdicts.size() == 0) begin
                $error("result item with no expectation: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got.alert !== want.alert) begin
                    $error("alert: expected %0d, got %0d", want.alert, got.alert);
                    mismatches++;
                end
                if (got.window_full !== want.window_full) begin
                    $error("window_full: expected %0d, got %0d",
                           want.window_full, got.window_full);
                    mismatches++;
                end
                if (got.median_sum !== want.median_sum) begin
                    $error("median_sum: expected %0d, got %0d",
                           want.median_sum, got.median_sum);
                    mismatches++;
                end
                if (got.alert_count !== want.alert_count) begin
                    $error("alert_count: expected %0d, got %0d",
                           want.alert_count, got.alert_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        bit                          taken;
        t_verdict                    predicted;
        logic [smsd_pkg::WLEN_W-1:0] len;
        logic [smsd_pkg::SAMPLE_W-1:0] s;
        mismatches     = 0;
        hold_pending   = 1'b0;
        sent_count     = 0;
        send_burst     = 1'b0;
        spike_total    = '0;
        window_setting = LEN_W'(smsd_pkg::WLEN_RESET);
        for (int i = 0; i < smsd_pkg::MAX_WINDOW; i++) begin
            past_samples[i] = '0;
        end
        restart_window();

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_sample(DIRECTED[r].sample, taken);
            predicted = spike_verdict(DIRECTED[r].sample);
            pending_verdicts.push_back(DIRECTED[r].typed ? DIRECTED[r].verdict : predicted);
        end
        s_axis_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            len = PHASE_PLAN[p].len;
            if (PHASE_PLAN[p].rand_len) begin
                len = LEN_W'($urandom_range(7, 40));
            end
            write_window_len(len);
            if (PHASE_PLAN[p].hold) begin
                hold_pending = 1'b1;
            end
            for (int n = 0; n < PHASE_PLAN[p].items; n++) begin
                s = draw_sample();
                send_sample(s, taken);
                pending_verdicts.push_back(spike_verdict(s));
            end
            s_axis_tvalid <= 1'b0;
        end

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
